FILE: rtl/core/tcw_pkg.sv
// tcw_pkg: shared types and constants of the text console writer.
// Holds the item structs, operation codes and screen geometry.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [6:0] LAST_COL = 7'(COLS - 1);
  localparam logic [4:0] LAST_ROW = 5'(ROWS - 1);

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_IDX   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_IDX = ADDR_W'(CELL_COUNT - COLS);

  // operation codes
  localparam logic [2:0] FUNC_PUT_CUR = 3'd0;
  localparam logic [2:0] FUNC_PUT_POS = 3'd1;
  localparam logic [2:0] FUNC_BKSP    = 3'd2;
  localparam logic [2:0] FUNC_CLEAR   = 3'd3;
  localparam logic [2:0] FUNC_READ    = 3'd4;

  localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
  localparam logic [7:0]  BLANK_CHAR   = 8'h20;
  localparam logic [7:0]  DEFAULT_ATTR = 8'h0F;
  localparam logic [15:0] BLANK_CELL   = {DEFAULT_ATTR, BLANK_CHAR};

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] char_code;
    logic [6:0] col;
    logic [4:0] row;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } out_item_t;

endpackage

FILE: rtl/core/text_console_writer.sv
// text_console_writer: text-mode console with a cell memory and a cursor.
// Depends on tcw_pkg for item structs, operation codes and geometry.
`timescale 1ns / 1ps

// The console keeps COLS x ROWS cells (character in the low byte, attribute in
// the high byte) in one single-port-write, registered-read memory, plus a
// cursor. One item is worked at a time. Put, backspace and unused codes go
// from accept to the done state and then to the output register; an in-range
// cell read first passes the read state, since the memory returns data in the
// cycle after the address. A put to the last cell, or a newline in the bottom
// row, scrolls: the block copies every cell one row up through the memory, one
// cell per cycle, then blanks the bottom row. Clear blanks the memory one cell
// per cycle. After reset the block runs a clearing pass with in_stall high;
// configuration writes are taken throughout. A result waits in the output
// register while stalled; the next item is accepted meanwhile, and its result
// waits until the register frees.
// The attribute register applies to characters written after the write; a
// value of zero writes the default attribute 0x0F.
module text_console_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  localparam int AW = tcw_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SCR,
    S_BLK,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [6:0]         cur_col_r;
  logic [4:0]         cur_row_r;
  logic [AW-1:0]      cur_idx_r;
  logic [7:0]         text_attr_r;
  logic [AW-1:0]      scan_r;
  logic               blk_report_r;
  logic               cp_vld_r;
  logic [AW-1:0]      cp_addr_r;
  logic [7:0]         res_char_r;
  logic [7:0]         res_attr_r;
  logic               res_scr_r;
  logic               out_valid_r;
  tcw_pkg::out_item_t out_item_r;

  // cell memory
  logic [15:0]   cell_mem [tcw_pkg::CELL_COUNT];
  logic [15:0]   rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  logic          in_acc;
  logic          out_free;
  logic [AW-1:0] in_pos;
  logic          in_range;
  logic          is_nl;
  logic [6:0]    p_col;
  logic [4:0]    p_row;
  logic [AW-1:0] p_idx;
  logic          p_ok;
  logic [7:0]    wr_attr;
  logic          wrap;
  logic          need_scroll;
  logic [6:0]    nx_col;
  logic [4:0]    nx_row;
  logic [AW-1:0] nx_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Item decode: target position, range check and the cursor after a put.
  always_comb begin
    in_pos   = AW'(in_item.row) * tcw_pkg::COLS_A + AW'(in_item.col);
    in_range = (in_item.col <= tcw_pkg::LAST_COL) && (in_item.row <= tcw_pkg::LAST_ROW);
    is_nl    = (in_item.char_code == tcw_pkg::NEWLINE_CODE);
    wr_attr  = (text_attr_r == 8'd0) ? tcw_pkg::DEFAULT_ATTR : text_attr_r;
    if (in_item.func == tcw_pkg::FUNC_PUT_POS) begin
      p_col = in_item.col;
      p_row = in_item.row;
      p_idx = in_pos;
      p_ok  = in_range;
    end else begin
      p_col = cur_col_r;
      p_row = cur_row_r;
      p_idx = cur_idx_r;
      p_ok  = 1'b1;
    end
    wrap        = is_nl || (p_col == tcw_pkg::LAST_COL);
    need_scroll = wrap && (p_row == tcw_pkg::LAST_ROW);
    if (need_scroll) begin
      nx_col = 7'd0;
      nx_row = tcw_pkg::LAST_ROW;
      nx_idx = tcw_pkg::BOTTOM_IDX;
    end else if (wrap) begin
      nx_col = 7'd0;
      nx_row = p_row + 5'd1;
      nx_idx = p_idx - AW'(p_col) + tcw_pkg::COLS_A;
    end else begin
      nx_col = p_col + 7'd1;
      nx_row = p_row;
      nx_idx = p_idx + AW'(1);
    end
  end

  // Memory port control: one read and at most one write per cycle.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cp_addr_r;
    mem_wd = rd_data_r;
    mem_ra = in_pos;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_item.func == tcw_pkg::FUNC_PUT_CUR ||
               in_item.func == tcw_pkg::FUNC_PUT_POS) && p_ok && !is_nl) begin
            mem_we = 1'b1;
            mem_wa = p_idx;
            mem_wd = {wr_attr, in_item.char_code};
          end else if (in_item.func == tcw_pkg::FUNC_BKSP && cur_idx_r != '0) begin
            mem_we = 1'b1;
            mem_wa = cur_idx_r - AW'(1);
            mem_wd = tcw_pkg::BLANK_CELL;
          end
        end
      end
      S_SCR: begin
        // copy the cell read last cycle one row up
        mem_ra = scan_r;
        mem_we = cp_vld_r;
      end
      S_BLK: begin
        // drain a pending copy before blanking
        mem_we = 1'b1;
        if (!cp_vld_r) begin
          mem_wa = scan_r;
          mem_wd = tcw_pkg::BLANK_CELL;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= cell_mem[mem_ra];
  end

  // Sequencer, cursor, attribute register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_BLK;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      cur_idx_r    <= '0;
      text_attr_r  <= tcw_pkg::DEFAULT_ATTR;
      scan_r       <= '0;
      blk_report_r <= 1'b0;
      cp_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        text_attr_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_char_r <= 8'd0;
            res_attr_r <= 8'd0;
            res_scr_r  <= 1'b0;
            state_r    <= S_DONE;
            case (in_item.func)
              tcw_pkg::FUNC_PUT_CUR, tcw_pkg::FUNC_PUT_POS: begin
                if (p_ok) begin
                  cur_col_r <= nx_col;
                  cur_row_r <= nx_row;
                  cur_idx_r <= nx_idx;
                  res_scr_r <= need_scroll;
                  if (need_scroll) begin
                    scan_r  <= tcw_pkg::COLS_A;
                    state_r <= S_SCR;
                  end
                end
              end
              tcw_pkg::FUNC_BKSP: begin
                if (cur_idx_r != '0) begin
                  cur_idx_r <= cur_idx_r - AW'(1);
                  if (cur_col_r == 7'd0) begin
                    cur_col_r <= tcw_pkg::LAST_COL;
                    cur_row_r <= cur_row_r - 5'd1;
                  end else begin
                    cur_col_r <= cur_col_r - 7'd1;
                  end
                end
              end
              tcw_pkg::FUNC_CLEAR: begin
                cur_col_r    <= '0;
                cur_row_r    <= '0;
                cur_idx_r    <= '0;
                scan_r       <= '0;
                blk_report_r <= 1'b1;
                state_r      <= S_BLK;
              end
              tcw_pkg::FUNC_READ: begin
                if (in_range) begin
                  state_r <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          res_char_r <= rd_data_r[7:0];
          res_attr_r <= rd_data_r[15:8];
          state_r    <= S_DONE;
        end
        S_SCR: begin
          cp_vld_r  <= 1'b1;
          cp_addr_r <= scan_r - tcw_pkg::COLS_A;
          if (scan_r == tcw_pkg::LAST_IDX) begin
            scan_r       <= tcw_pkg::BOTTOM_IDX;
            blk_report_r <= 1'b1;
            state_r      <= S_BLK;
          end else begin
            scan_r <= scan_r + AW'(1);
          end
        end
        S_BLK: begin
          if (cp_vld_r) begin
            cp_vld_r <= 1'b0;
          end else if (scan_r == tcw_pkg::LAST_IDX) begin
            state_r <= blk_report_r ? S_DONE : S_IDLE;
          end else begin
            scan_r <= scan_r + AW'(1);
          end
        end
        S_DONE: begin
          // hold the result until the output register frees
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_item_r.cursor_col <= cur_col_r;
            out_item_r.cursor_row <= cur_row_r;
            out_item_r.cell_char  <= res_char_r;
            out_item_r.cell_attr  <= res_attr_r;
            out_item_r.scrolled   <= res_scr_r;
            state_r               <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_col_r <= tcw_pkg::LAST_COL) && (cur_row_r <= tcw_pkg::LAST_ROW))
    else $error("cursor left the screen");

  // linear cursor index tracks column and row
  a_cursor_index: assert property (@(posedge clk) disable iff (!rst_n)
    cur_idx_r == AW'(cur_row_r) * tcw_pkg::COLS_A + AW'(cur_col_r))
    else $error("cursor index out of step with column and row");

  // a scroll copy never lands in the bottom row
  a_copy_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> (cp_addr_r < tcw_pkg::BOTTOM_IDX))
    else $error("scroll copy aimed at bottom row");

  // a scrolled result leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.scrolled) |->
      (out_item_r.cursor_col == 7'd0 && out_item_r.cursor_row == tcw_pkg::LAST_ROW))
    else $error("scroll left cursor off bottom row start");

  // a copy is pending only while scrolling or draining into the blank pass
  a_copy_state: assert property (@(posedge clk) disable iff (!rst_n)
    cp_vld_r |-> (state_r == S_SCR || state_r == S_BLK))
    else $error("scroll copy pending outside scroll");

endmodule
